// ===== rtl/fwt_pkg.sv =====
// fenwick tree unit: shared types, field widths and operation codes
// no dependencies; imported by every module of the unit
`default_nettype none

package fwt_pkg;

    // default number of tree entries
    localparam int unsigned DEPTH_DEFAULT = 1024;

    // field widths fixed by the interface
    localparam int SIZE_W = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 64;
    localparam int KIND_W = 2;

    // size register after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // input word
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         index_low;
        logic [IDX_W-1:0]         index_high;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     status;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_en;         // write zero at the clear address, step it
        logic load_item;      // capture input word
        logic start_a;        // first prefix walk: walk <= high+1 (low+1 for a set), acc <= 0
        logic start_b;        // second prefix walk: save acc, walk <= low index, acc <= 0
        logic start_upd;      // update walk: walk <= low index, latch delta
        logic delta_from_res; // delta = value - point value instead of value
        logic mem_rd;         // read tree entry
        logic rd_prefix;      // read address is walk - 1
        logic acc_add;        // acc += read data, drop lowest set bit of walk
        logic upd_wr;         // write read data + delta, step walk upward
        logic res_zero;       // result: sum 0, status 0
        logic res_err;        // result: sum 0, status 1
        logic res_diff;       // result: difference of the two prefix sums
        logic out_load;       // move result into the output register
    } fwt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic clr_last;   // clearing pass at its last entry
        logic walk_zero;  // prefix walk finished
        logic walk_live;  // update walk index still inside the size in use
        logic pt_oor;     // point index at or beyond the size in use
        logic rng_empty;  // query low above high
        logic rng_oor;    // query high at or beyond the size in use
        logic out_free;   // output register can take a word this cycle
    } fwt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fwt_ctrl.sv =====
// fenwick tree unit: sequencing state machine
// depends on fwt_pkg; drives the command struct of fwt_datapath
`default_nettype none

module fwt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fwt_pkg::fwt_stat_t stat,
    output fwt_pkg::fwt_cmd_t      cmd
);
    import fwt_pkg::*;

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_DECODE = 11'b000_0000_0100,
        ST_A_RD   = 11'b000_0000_1000,
        ST_A_ACC  = 11'b000_0001_0000,
        ST_B_RD   = 11'b000_0010_0000,
        ST_B_ACC  = 11'b000_0100_0000,
        ST_DELTA  = 11'b000_1000_0000,
        ST_UPD_RD = 11'b001_0000_0000,
        ST_UPD_WR = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // new words only in idle
    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.kind)
                    KIND_ADD: begin
                        if (stat.pt_oor) begin
                            cmd.res_err = 1'b1;
                            state_next  = ST_FINISH;
                        end else begin
                            cmd.start_upd = 1'b1;
                            cmd.res_zero  = 1'b1;
                            state_next    = ST_UPD_RD;
                        end
                    end
                    KIND_SET: begin
                        if (stat.pt_oor) begin
                            cmd.res_err = 1'b1;
                            state_next  = ST_FINISH;
                        end else begin
                            cmd.start_a = 1'b1;
                            state_next  = ST_A_RD;
                        end
                    end
                    KIND_QUERY: begin
                        if (stat.rng_empty) begin
                            cmd.res_zero = 1'b1;
                            state_next   = ST_FINISH;
                        end else if (stat.rng_oor) begin
                            cmd.res_err = 1'b1;
                            state_next  = ST_FINISH;
                        end else begin
                            cmd.start_a = 1'b1;
                            state_next  = ST_A_RD;
                        end
                    end
                    default: begin
                        cmd.res_zero = 1'b1;
                        state_next   = ST_FINISH;
                    end
                endcase
            end
            ST_A_RD: begin
                if (stat.walk_zero) begin
                    cmd.start_b = 1'b1;
                    state_next  = ST_B_RD;
                end else begin
                    cmd.mem_rd    = 1'b1;
                    cmd.rd_prefix = 1'b1;
                    state_next    = ST_A_ACC;
                end
            end
            ST_A_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_A_RD;
            end
            ST_B_RD: begin
                if (stat.walk_zero) begin
                    cmd.res_diff = 1'b1;
                    state_next   = (stat.kind == KIND_SET) ? ST_DELTA : ST_FINISH;
                end else begin
                    cmd.mem_rd    = 1'b1;
                    cmd.rd_prefix = 1'b1;
                    state_next    = ST_B_ACC;
                end
            end
            ST_B_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_B_RD;
            end
            ST_DELTA: begin
                cmd.start_upd      = 1'b1;
                cmd.delta_from_res = 1'b1;
                cmd.res_zero       = 1'b1;
                state_next         = ST_UPD_RD;
            end
            ST_UPD_RD: begin
                if (stat.walk_live) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_UPD_WR;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                state_next = ST_UPD_RD;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, clearing pass first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fwt_datapath.sv =====
// fenwick tree unit: tree memory, walk index, accumulators and result registers
// depends on fwt_pkg; commanded by fwt_ctrl
`default_nettype none

module fwt_datapath #(
    parameter int unsigned DEPTH = fwt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fwt_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  wire fwt_pkg::in_word_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output fwt_pkg::out_word_t               m_data,
    input  wire fwt_pkg::fwt_cmd_t           cmd,
    output fwt_pkg::fwt_stat_t               stat
);
    import fwt_pkg::*;

    // address width, and walk width that holds the size and one step past it
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

    logic [SIZE_W-1:0]        size_reg;
    in_word_t                 item_reg;
    logic [WW-1:0]            walk_reg;
    logic [WW-1:0]            walk_next;
    logic [DATA_W-1:0]        acc_reg;
    logic [DATA_W-1:0]        acc_next;
    logic [DATA_W-1:0]        suma_reg;
    logic [DATA_W-1:0]        delta_reg;
    logic [DATA_W-1:0]        res_sum_reg;
    logic                     res_status_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic [AW-1:0]            clr_addr_reg;
    out_word_t                out_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic [DATA_W-1:0]        tree_mem [DEPTH];

    logic [WW-1:0]            size_w;
    logic [WW-1:0]            depth_w;
    logic [WW-1:0]            n_live;
    logic [WW-1:0]            lo_w;
    logic [WW-1:0]            hi_w;
    logic [WW-1:0]            count_a;
    logic [WW-1:0]            walk_dec;
    logic [WW-1:0]            walk_up;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     mem_we;

    // size in use, capped at the depth
    assign size_w  = WW'(size_reg);
    assign depth_w = WW'(DEPTH);
    assign n_live  = (size_w > depth_w) ? depth_w : size_w;

    // indices of the held word
    assign lo_w    = {{(WW-IDX_W){1'b0}}, item_reg.index_low};
    assign hi_w    = {{(WW-IDX_W){1'b0}}, item_reg.index_high};
    assign count_a = ((item_reg.kind == KIND_SET) ? lo_w : hi_w) + WW'(1);

    // walk steps: downward drops the lowest set bit, upward sets the lowest clear bit
    assign walk_dec = walk_reg - WW'(1);
    assign walk_up  = walk_reg | (walk_reg + WW'(1));

    // status
    assign stat.kind      = item_reg.kind;
    assign stat.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.walk_zero = (walk_reg == '0);
    assign stat.walk_live = (walk_reg < n_live);
    assign stat.pt_oor    = (lo_w >= n_live);
    assign stat.rng_empty = (lo_w > hi_w);
    assign stat.rng_oor   = (hi_w >= n_live);
    assign stat.out_free  = !out_valid_reg || m_ready;

    // memory port addresses and write data
    assign rd_addr = cmd.rd_prefix ? walk_dec[AW-1:0] : walk_reg[AW-1:0];
    assign wr_addr = cmd.clr_en ? clr_addr_reg : walk_reg[AW-1:0];
    assign wr_data = cmd.clr_en ? '0 : (rd_data_reg + delta_reg);
    assign mem_we  = cmd.clr_en || cmd.upd_wr;

    // tree memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tree_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= tree_mem[rd_addr];
        end
    end

    // walk index and accumulator
    always_comb begin
        walk_next = walk_reg;
        acc_next  = acc_reg;
        if (cmd.start_a) begin
            walk_next = count_a;
            acc_next  = '0;
        end else if (cmd.start_b || cmd.start_upd) begin
            walk_next = lo_w;
            if (cmd.start_b) begin
                acc_next = '0;
            end
        end else if (cmd.acc_add) begin
            walk_next = walk_reg & walk_dec;
            acc_next  = acc_reg + rd_data_reg;
        end else if (cmd.upd_wr) begin
            walk_next = walk_up;
        end
    end

    // output handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SIZE_RESET;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        walk_reg <= walk_next;
        acc_reg  <= acc_next;
        if (cmd.start_b) begin
            suma_reg <= acc_reg;
        end
        if (cmd.start_upd) begin
            delta_reg <= cmd.delta_from_res ? (item_reg.value - res_sum_reg)
                                            : item_reg.value;
        end
        if (cmd.res_zero || cmd.res_err) begin
            res_sum_reg    <= '0;
            res_status_reg <= cmd.res_err;
        end else if (cmd.res_diff) begin
            res_sum_reg    <= suma_reg - acc_reg;
            res_status_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg.range_sum <= res_sum_reg;
            out_reg.status    <= res_status_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // an update write stays inside the size in use
    a_upd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd_wr |-> (walk_reg < n_live))
        else $error("update write beyond size in use");

    // a prefix accumulate never runs on a finished walk
    a_acc_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_add |-> (walk_reg != '0))
        else $error("accumulate on zero walk index");

    // a waiting result is never overwritten
    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("output word overwritten before taken");

    // clearing and updates never share the write port
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_en && (cmd.upd_wr || cmd.load_item)))
        else $error("clearing pass overlaps item work");

endmodule

`default_nettype wire

// ===== rtl/fenwick_tree_point_update_range_sum_unit.sv =====
// fenwick tree unit: top level joining the sequencer and the datapath
// depends on fwt_pkg, fwt_ctrl and fwt_datapath
`default_nettype none

// Binary indexed tree over DEPTH signed 64-bit partial sums, one word at a time.
// After reset a clearing pass zeroes the tree memory, one entry per cycle, so
// no word is taken until it ends; the size register can be written meanwhile.
// Every tree access is a read of the single memory port followed by an
// accumulate or write-back step, so time per word follows the walk lengths:
// an add reads and writes back each entry that the upward walk touches (at
// most log2(size)+1); a query walks down over the set bits of high+1 and then
// of low; a set does the same with low+1 in place of high+1, then walks up
// like an add. Range and index errors, empty ranges and unknown operations
// finish without a memory access. A finished word sits in the output register
// while the next word is taken. Arithmetic wraps modulo 2^64.
module fenwick_tree_point_update_range_sum_unit #(
    parameter int unsigned DEPTH = fwt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [fwt_pkg::SIZE_W-1:0] cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire fwt_pkg::in_word_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output fwt_pkg::out_word_t              m_data
);
    import fwt_pkg::*;

    fwt_cmd_t  cmd;
    fwt_stat_t stat;

    // sequencer
    fwt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tree memory and arithmetic
    fwt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_fenwick_tree_point_update_range_sum_unit.sv =====
// self-checking testbench for the fenwick tree point update / range sum unit
// depends on fwt_pkg and fenwick_tree_point_update_range_sum_unit; keeps its own tree mirror
// directed corner words, then randomized phases over several sizes with random stalls
module tb_fenwick_tree_point_update_range_sum_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import fwt_pkg::*;

    localparam int unsigned TREE_DEPTH = DEPTH_DEFAULT;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned WORDS_PER_PHASE = 100;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_word_t         m_data;

    // mirror of the tree memory and the size register
    logic [DATA_W-1:0] tree_mirror [0:TREE_DEPTH-1];
    logic [SIZE_W-1:0] size_mirror = SIZE_RESET;

    in_word_t  pending_words [$];
    out_word_t awaited_results [$];

    // handshake and idle control for the driver, back-pressure, monitor and sequence
    bit          word_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles = 0;

    // bookkeeping for the summary
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned adds_seen = 0;
    int unsigned sets_seen = 0;
    int unsigned queries_seen = 0;
    int unsigned unused_seen = 0;
    int unsigned flagged_seen = 0;
    int unsigned size_writes = 0;

    fenwick_tree_point_update_range_sum_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // sum of points 0 .. count-1 read from the mirror
    function automatic logic [DATA_W-1:0] prefix_total(int unsigned count);
        logic [DATA_W-1:0] acc;
        int unsigned j;
        acc = '0;
        j = count;
        while (j > 0) begin
            acc += tree_mirror[j-1];
            j = j & (j - 1);
        end
        return acc;
    endfunction

    // apply one word to the mirror and return the result it should produce
    function automatic out_word_t apply_tree_op(in_word_t w);
        out_word_t r;
        int unsigned live;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        logic [DATA_W-1:0] delta;
        r.range_sum = '0;
        r.status = 1'b0;
        live = (size_mirror > TREE_DEPTH) ? TREE_DEPTH : size_mirror;
        lo = w.index_low;
        hi = w.index_high;
        case (w.kind)
            KIND_ADD, KIND_SET: begin
                if (lo >= live) begin
                    r.status = 1'b1;
                end else begin
                    delta = w.value;
                    // set turns into an add of the difference to the current point value
                    if (w.kind == KIND_SET)
                        delta = w.value - (prefix_total(lo + 1) - prefix_total(lo));
                    k = lo;
                    while (k < live) begin
                        tree_mirror[k] += delta;
                        k = k | (k + 1);
                    end
                end
            end
            KIND_QUERY: begin
                if (lo > hi)
                    r.range_sum = '0;
                else if (hi >= live)
                    r.status = 1'b1;
                else
                    r.range_sum = prefix_total(hi + 1) - prefix_total(lo);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatches++;
        $display("%0t ns: %s mismatch, got %h want %h", $time, field, got, want);
    endtask

    // input driver: holds each word until taken, random gaps between words
    always @(negedge aclk) begin
        if (!s_valid || word_taken) begin
            word_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
                if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
                    send_gap = $urandom_range(7, 1);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
            stall_left = $urandom_range(6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: size writes, result check, accepted words, watchdog
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (cfg_wr_en)
                size_mirror = cfg_wr_data;

            if (m_valid && m_ready) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data.range_sum, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.range_sum !== want.range_sum)
                        report_mismatch("range_sum", m_data.range_sum, want.range_sum);
                    if (m_data.status !== want.status)
                        report_mismatch("status", 64'(m_data.status), 64'(want.status));
                end
            end

            if (s_valid && s_ready) begin
                case (s_data.kind)
                    KIND_ADD:   adds_seen++;
                    KIND_SET:   sets_seen++;
                    KIND_QUERY: queries_seen++;
                    default:    unused_seen++;
                endcase
                want = apply_tree_op(s_data);
                if (want.status)
                    flagged_seen++;
                awaited_results.push_back(want);
                word_taken = 1'b1;
                words_taken++;
            end
        end

        // watchdog on cycles without any handshake
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_word(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] lo,
                              logic [IDX_W-1:0] hi, logic [DATA_W-1:0] value);
        in_word_t w;
        w.kind = kind;
        w.index_low = lo;
        w.index_high = hi;
        w.value = value;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // mostly inside the live size, sometimes anywhere in the index field
    function automatic logic [IDX_W-1:0] pick_index(int unsigned live);
        if (live > 0 && $urandom_range(9) < 8)
            return IDX_W'($urandom_range(live - 1));
        return IDX_W'($urandom_range(1023));
    endfunction

    task automatic queue_random_word(int unsigned live);
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] swap;
        logic signed [DATA_W-1:0] value;
        int unsigned roll;
        int near_zero;
        roll = $urandom_range(99);
        if (roll < 35)
            kind = KIND_ADD;
        else if (roll < 60)
            kind = KIND_SET;
        else if (roll < 95)
            kind = KIND_QUERY;
        else
            kind = KIND_UNUSED;
        lo = pick_index(live);
        hi = pick_index(live);
        // most ranges are well ordered
        if (kind == KIND_QUERY && lo > hi && $urandom_range(3) != 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        near_zero = int'($urandom_range(2000)) - 1000;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: value = DATA_W'(near_zero);
            5, 6, 7:       value = {$urandom, $urandom};
            8:             value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default:       value = $urandom_range(1) ? '1 : '0;
        endcase
        queue_word(kind, lo, hi, value);
    endtask

    // wait until every queued word has been taken and answered
    task automatic wait_drained();
        while (words_taken != words_queued || awaited_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] size);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        size_writes++;
    endtask

    // stimulus sequence
    initial begin
        int unsigned p;
        int unsigned i;
        int unsigned live;
        logic [SIZE_W-1:0] phase_size;

        for (i = 0; i < TREE_DEPTH; i++)
            tree_mirror[i] = '0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 25;

        // directed words at the reset size: extremes, wrap, set, empty ranges
        queue_word(KIND_ADD, 10'd0, 10'd1023, VAL_MAX);
        queue_word(KIND_ADD, 10'd1023, 10'd0, VAL_MIN);
        queue_word(KIND_ADD, 10'd512, 10'd0, '1);
        queue_word(KIND_SET, 10'd512, 10'd0, 64'd123);
        queue_word(KIND_SET, 10'd0, 10'd0, VAL_MIN);
        queue_word(KIND_ADD, 10'd0, 10'd0, VAL_MIN);
        queue_word(KIND_QUERY, 10'd0, 10'd1023, '0);
        queue_word(KIND_QUERY, 10'd0, 10'd0, '1);
        queue_word(KIND_QUERY, 10'd1023, 10'd1023, '0);
        queue_word(KIND_QUERY, 10'd512, 10'd511, '0);
        queue_word(KIND_QUERY, 10'd1023, 10'd0, '0);
        queue_word(KIND_UNUSED, 10'd1023, 10'd1023, VAL_MAX);
        queue_word(KIND_SET, 10'd1023, 10'd1023, '0);
        wait_drained();

        // small size: point and range errors at the boundary
        write_size(11'd10);
        queue_word(KIND_ADD, 10'd9, 10'd0, 64'd5);
        queue_word(KIND_ADD, 10'd10, 10'd0, 64'd7);
        queue_word(KIND_SET, 10'd12, 10'd3, 64'd9);
        queue_word(KIND_QUERY, 10'd3, 10'd10, '0);
        queue_word(KIND_QUERY, 10'd0, 10'd9, '0);
        queue_word(KIND_QUERY, 10'd11, 10'd2, '0);
        wait_drained();

        // size zero: everything out of range except an empty range
        write_size(11'd0);
        queue_word(KIND_ADD, 10'd0, 10'd0, 64'd1);
        queue_word(KIND_QUERY, 10'd0, 10'd0, '0);
        queue_word(KIND_QUERY, 10'd1, 10'd0, '0);
        queue_word(KIND_SET, 10'd0, 10'd0, VAL_MAX);
        wait_drained();

        // size above the depth is clamped
        write_size(11'd2047);
        queue_word(KIND_QUERY, 10'd0, 10'd1023, '0);
        queue_word(KIND_ADD, 10'd1023, 10'd0, 64'd1);
        queue_word(KIND_QUERY, 10'd1000, 10'd1023, '0);
        wait_drained();

        // random phases; shrinking then growing the size leaves stale upper entries
        for (p = 0; p < 7; p++) begin
            case (p)
                0:       phase_size = 11'd1;
                1:       phase_size = 11'd3;
                2:       phase_size = 11'd100;
                3:       phase_size = 11'd2047;
                4:       phase_size = SIZE_W'($urandom_range(1023, 2));
                5:       phase_size = 11'd1023;
                default: phase_size = 11'd1024;
            endcase
            write_size(phase_size);
            live = (phase_size > TREE_DEPTH) ? TREE_DEPTH : phase_size;
            send_idle_pct = (p == 2 || p == 6) ? 0 : 30;
            recv_idle_pct = (p == 4 || p == 6) ? 0 : 35;
            for (i = 0; i < WORDS_PER_PHASE; i++)
                queue_random_word(live);
            wait_drained();
        end

        repeat (100) @(negedge aclk);
        $display("covered %0d adds, %0d sets, %0d queries, %0d unused codes over %0d size writes",
                 adds_seen, sets_seen, queries_seen, unused_seen, size_writes);
        $display("%0d results checked, %0d flagged out of range", results_checked, flagged_seen);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
